### hdl/hrlp_pkg.sv
// hrlp_pkg: types, codes and constant tables for the http request line parser
// no dependencies; imported by http_request_line_parser
`default_nettype none

package hrlp_pkg;

  localparam int NUM_METHODS = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int GET_IDX     = 1;

  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_TARGET  = 2'd1,
    PH_VERSION = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CR_NONE  = 2'd0,
    CR_CR    = 2'd1,
    CR_FOUND = 2'd2
  } crlf_t;

  typedef enum logic [1:0] {
    KIND_PATH    = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_VERSION   = 3'd2,
    ST_METHOD    = 3'd3,
    ST_NO_SLASH  = 3'd4,
    ST_QUOTE     = 3'd5
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic       last;
  } result_t;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // OPTIONS GET HEAD POST PUT DELETE TRACE CONNECT, zero padded to eight bytes
  localparam logic [7:0] METHOD_TEXT [NUM_METHODS][8] = '{
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
  };

  localparam logic [2:0] METHOD_LEN [NUM_METHODS] = '{
    3'd7, 3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7
  };

  localparam logic [7:0] VERSION_TEXT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
  localparam logic [3:0] VERSION_LEN = 4'd8;

endpackage

`default_nettype wire

### hdl/http_request_line_parser.sv
// http_request_line_parser: splits an http request line into path and query bytes
// and a final verdict beat; depends on hdl/hrlp_pkg.sv
// result beats are registered into the result queue, whose head drives out_*
// throughput: one input beat per cycle unless in_stall; a target byte ending the line
//   makes two output beats, from a four-entry result queue one per cycle unless out_stall
// in_stall rises only when the result queue has fewer than two free entries
// reset (rst_n low, synchronous) returns the parser to the method token, empties the queue
`default_nettype none

module http_request_line_parser (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       in_char_byte,
  input  wire              in_end_of_line,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_status,
  output logic             out_last
);
  import hrlp_pkg::*;

  // parse state
  phase_t                   phase_r, phase_nxt;
  logic [1:0]               space_cnt_r, space_cnt_nxt;
  logic [2:0]               method_pos_r, method_pos_nxt;
  logic [NUM_METHODS-1:0]   method_match_r, method_match_nxt;
  logic [3:0]               version_pos_r, version_pos_nxt;
  logic                     version_ok_r, version_ok_nxt;
  logic                     target_started_r, target_started_nxt;
  logic                     no_slash_r, no_slash_nxt;
  logic                     quote_seen_r, quote_seen_nxt;
  logic                     question_seen_r, question_seen_nxt;
  crlf_t                    crlf_r, crlf_nxt;
  logic                     after_crlf_r, after_crlf_nxt;

  // result queue
  result_t                  queue_r [FIFO_DEPTH];
  logic [1:0]               wr_ptr_r, rd_ptr_r;
  logic [2:0]               count_r, count_nxt;

  logic       in_accept;
  logic       out_accept;
  logic       prev_cr;
  logic       found_before;
  logic       tgt_emit;
  kind_t      tgt_kind;
  status_t    verdict;
  result_t    slot0, slot1;
  logic [1:0] push_cnt;

  // room for the worst case of two beats per input
  assign in_stall   = (count_r > 3'(FIFO_DEPTH - 2));
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count_r != 3'd0);
  assign out_accept = out_valid && !out_stall;

  // per-byte parse, one pass
  always_comb begin
    phase_nxt          = phase_r;
    space_cnt_nxt      = space_cnt_r;
    method_pos_nxt     = method_pos_r;
    method_match_nxt   = method_match_r;
    version_pos_nxt    = version_pos_r;
    version_ok_nxt     = version_ok_r;
    target_started_nxt = target_started_r;
    no_slash_nxt       = no_slash_r;
    quote_seen_nxt     = quote_seen_r;
    question_seen_nxt  = question_seen_r;
    crlf_nxt           = crlf_r;
    after_crlf_nxt     = after_crlf_r;
    tgt_emit           = 1'b0;
    tgt_kind           = KIND_PATH;
    prev_cr            = (crlf_r == CR_CR);
    found_before       = (crlf_r == CR_FOUND);

    if (in_char_byte == CH_SP) begin
      if (space_cnt_r != 2'd3) space_cnt_nxt = space_cnt_r + 2'd1;
      // method token closes: length must match exactly
      if (phase_r == PH_METHOD) begin
        for (int m = 0; m < NUM_METHODS; m++) begin
          if (METHOD_LEN[m] != method_pos_r) method_match_nxt[m] = 1'b0;
        end
      end
      if (phase_r == PH_VERSION && prev_cr) version_ok_nxt = 1'b0;
      case (phase_r)
        PH_METHOD:  phase_nxt = PH_TARGET;
        PH_TARGET:  phase_nxt = PH_VERSION;
        PH_VERSION: phase_nxt = PH_DONE;
        default:    phase_nxt = PH_DONE;
      endcase
    end else begin
      case (phase_r)
        PH_METHOD: begin
          for (int m = 0; m < NUM_METHODS; m++) begin
            if (method_pos_r >= METHOD_LEN[m] ||
                METHOD_TEXT[m][method_pos_r] != in_char_byte) begin
              method_match_nxt[m] = 1'b0;
            end
          end
          if (method_pos_r != 3'd7) method_pos_nxt = method_pos_r + 3'd1;
        end
        PH_TARGET: begin
          if (!target_started_r) begin
            target_started_nxt = 1'b1;
            if (in_char_byte != CH_SLASH) no_slash_nxt = 1'b1;
          end
          if (in_char_byte == CH_QUOTE) quote_seen_nxt = 1'b1;
          // first '?' splits path from query and is dropped
          if (in_char_byte == CH_QMARK && !question_seen_r) begin
            question_seen_nxt = 1'b1;
          end else begin
            tgt_emit = 1'b1;
            tgt_kind = question_seen_r ? KIND_QUERY : KIND_PATH;
          end
        end
        PH_VERSION: begin
          if (!found_before) begin
            // stray cr spoils the version
            if (prev_cr && in_char_byte != CH_LF) version_ok_nxt = 1'b0;
            if (in_char_byte != CH_CR && !(prev_cr && in_char_byte == CH_LF)) begin
              if (version_pos_r >= VERSION_LEN ||
                  VERSION_TEXT[version_pos_r[2:0]] != in_char_byte) begin
                version_ok_nxt = 1'b0;
              end
              if (version_pos_r != 4'd15) version_pos_nxt = version_pos_r + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // line terminator tracking
    if (found_before)                          after_crlf_nxt = 1'b1;
    else if (prev_cr && in_char_byte == CH_LF) crlf_nxt = CR_FOUND;
    else if (in_char_byte == CH_CR)            crlf_nxt = CR_CR;
    else                                       crlf_nxt = CR_NONE;

    // verdict in priority order, from the updated state
    if (crlf_nxt != CR_FOUND || after_crlf_nxt || space_cnt_nxt != 2'd2 ||
        method_match_nxt == '0) begin
      verdict = ST_MALFORMED;
    end else if (!version_ok_nxt || version_pos_nxt != VERSION_LEN) begin
      verdict = ST_VERSION;
    end else if (!method_match_nxt[GET_IDX]) begin
      verdict = ST_METHOD;
    end else if (!target_started_nxt || no_slash_nxt) begin
      verdict = ST_NO_SLASH;
    end else if (quote_seen_nxt) begin
      verdict = ST_QUOTE;
    end else begin
      verdict = ST_OK;
    end

    // end of line: back to the start for the next line
    if (in_end_of_line) begin
      phase_nxt          = PH_METHOD;
      space_cnt_nxt      = 2'd0;
      method_pos_nxt     = 3'd0;
      method_match_nxt   = '1;
      version_pos_nxt    = 4'd0;
      version_ok_nxt     = 1'b1;
      target_started_nxt = 1'b0;
      no_slash_nxt       = 1'b0;
      quote_seen_nxt     = 1'b0;
      question_seen_nxt  = 1'b0;
      crlf_nxt           = CR_NONE;
      after_crlf_nxt     = 1'b0;
    end

    // result beats: target byte first, verdict after
    slot1 = '{kind: KIND_VERDICT, data: 8'h00, status: verdict, last: 1'b1};
    if (tgt_emit) begin
      slot0 = '{kind: tgt_kind, data: in_char_byte, status: ST_OK, last: 1'b0};
    end else begin
      slot0 = slot1;
    end
    push_cnt = 2'({1'b0, tgt_emit} + {1'b0, in_end_of_line});
  end

  // queue occupancy
  always_comb begin
    count_nxt = count_r;
    if (in_accept) count_nxt = count_nxt + 3'(push_cnt);
    if (out_accept) count_nxt = count_nxt - 3'd1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_METHOD;
      space_cnt_r      <= 2'd0;
      method_pos_r     <= 3'd0;
      method_match_r   <= '1;
      version_pos_r    <= 4'd0;
      version_ok_r     <= 1'b1;
      target_started_r <= 1'b0;
      no_slash_r       <= 1'b0;
      quote_seen_r     <= 1'b0;
      question_seen_r  <= 1'b0;
      crlf_r           <= CR_NONE;
      after_crlf_r     <= 1'b0;
      wr_ptr_r         <= 2'd0;
      rd_ptr_r         <= 2'd0;
      count_r          <= 3'd0;
    end else begin
      if (in_accept) begin
        phase_r          <= phase_nxt;
        space_cnt_r      <= space_cnt_nxt;
        method_pos_r     <= method_pos_nxt;
        method_match_r   <= method_match_nxt;
        version_pos_r    <= version_pos_nxt;
        version_ok_r     <= version_ok_nxt;
        target_started_r <= target_started_nxt;
        no_slash_r       <= no_slash_nxt;
        quote_seen_r     <= quote_seen_nxt;
        question_seen_r  <= question_seen_nxt;
        crlf_r           <= crlf_nxt;
        after_crlf_r     <= after_crlf_nxt;
        wr_ptr_r         <= wr_ptr_r + push_cnt;
      end
      if (out_accept) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_nxt;
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk) begin
    if (in_accept && push_cnt != 2'd0) begin
      queue_r[wr_ptr_r] <= slot0;
      if (push_cnt == 2'd2) queue_r[wr_ptr_r + 2'd1] <= slot1;
    end
  end

  assign out_kind   = queue_r[rd_ptr_r].kind;
  assign out_byte   = queue_r[rd_ptr_r].data;
  assign out_status = queue_r[rd_ptr_r].status;
  assign out_last   = queue_r[rd_ptr_r].last;

endmodule

`default_nettype wire

### test/hrlp_checker.sv
// hrlp_checker: watches both channels of http_request_line_parser, predicts every
// result beat from the accepted input bytes and compares them field by field
// depends on hdl/hrlp_pkg.sv for the kind and status codes and the character constants
`timescale 1ns / 1ps

module hrlp_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire  [7:0] in_char_byte,
  input  wire        in_end_of_line,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire  [1:0] out_kind,
  input  wire  [7:0] out_byte,
  input  wire  [2:0] out_status,
  input  wire        out_last,
  input  wire        flush,
  output int         fail_count,
  output int         pending,
  output int         beats_checked,
  output int         verdicts_checked
);

  import hrlp_pkg::*;

  string verb_names [8] = '{"OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE",
                            "CONNECT"};
  string http_11 = "HTTP/1.1";

  // line state of the predictor
  phase_t     ph;
  logic [1:0] spaces;
  logic [2:0] verb_pos;
  logic [7:0] verb_hits;
  logic [3:0] ver_pos;
  logic       ver_good;
  logic       tgt_started;
  logic       tgt_no_slash;
  logic       tgt_quote;
  logic       tgt_qmark;
  crlf_t      crlf;
  logic       trailing;

  result_t    expected_beats [$];
  result_t    want;
  int         n_fails    = 0;
  int         n_checked  = 0;
  int         n_verdicts = 0;
  bit         flushed    = 1'b0;

  task report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    n_fails++;
  endtask

  task clear_line_state();
    ph           = PH_METHOD;
    spaces       = 2'd0;
    verb_pos     = 3'd0;
    verb_hits    = 8'hff;
    ver_pos      = 4'd0;
    ver_good     = 1'b1;
    tgt_started  = 1'b0;
    tgt_no_slash = 1'b0;
    tgt_quote    = 1'b0;
    tgt_qmark    = 1'b0;
    crlf         = CR_NONE;
    trailing     = 1'b0;
  endtask

  // one accepted byte: update the line state, queue the beats it causes
  task take_byte(input logic [7:0] b, input logic eol);
    logic    prev_cr;
    logic    found_before;
    result_t beat;
    status_t st;
    prev_cr      = (crlf == CR_CR);
    found_before = (crlf == CR_FOUND);
    if (b == CH_SP) begin
      if (spaces != 2'd3) spaces++;
      if (ph == PH_METHOD) begin
        for (int m = 0; m < 8; m++)
          if (verb_names[m].len() != verb_pos) verb_hits[m] = 1'b0;
      end
      if (ph == PH_VERSION && prev_cr) ver_good = 1'b0;
      if (ph != PH_DONE) ph = phase_t'(ph + 2'd1);
    end else if (ph == PH_METHOD) begin
      for (int m = 0; m < 8; m++)
        if (verb_pos >= verb_names[m].len() || verb_names[m][verb_pos] != b)
          verb_hits[m] = 1'b0;
      if (verb_pos != 3'd7) verb_pos++;
    end else if (ph == PH_TARGET) begin
      if (!tgt_started) begin
        tgt_started = 1'b1;
        if (b != CH_SLASH) tgt_no_slash = 1'b1;
      end
      if (b == CH_QUOTE) tgt_quote = 1'b1;
      if (b == CH_QMARK && !tgt_qmark) begin
        tgt_qmark = 1'b1;
      end else begin
        beat.kind   = tgt_qmark ? KIND_QUERY : KIND_PATH;
        beat.data   = b;
        beat.status = ST_OK;
        beat.last   = 1'b0;
        expected_beats.push_back(beat);
      end
    end else if (ph == PH_VERSION && !found_before) begin
      if (prev_cr && b != CH_LF) ver_good = 1'b0;
      if (b != CH_CR && !(prev_cr && b == CH_LF)) begin
        if (ver_pos >= 4'd8 || http_11[ver_pos] != b) ver_good = 1'b0;
        if (ver_pos != 4'd15) ver_pos++;
      end
    end

    if (found_before) trailing = 1'b1;
    else if (prev_cr && b == CH_LF) crlf = CR_FOUND;
    else if (b == CH_CR) crlf = CR_CR;
    else crlf = CR_NONE;

    if (eol) begin
      if (crlf != CR_FOUND || trailing || spaces != 2'd2 || verb_hits == 8'h00)
        st = ST_MALFORMED;
      else if (!ver_good || ver_pos != 4'd8)
        st = ST_VERSION;
      else if (!verb_hits[GET_IDX])
        st = ST_METHOD;
      else if (!tgt_started || tgt_no_slash)
        st = ST_NO_SLASH;
      else if (tgt_quote)
        st = ST_QUOTE;
      else
        st = ST_OK;
      beat.kind   = KIND_VERDICT;
      beat.data   = 8'h00;
      beat.status = st;
      beat.last   = 1'b1;
      expected_beats.push_back(beat);
      clear_line_state();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line_state();
      expected_beats.delete();
    end else begin
      if (in_valid && !in_stall) take_byte(in_char_byte, in_end_of_line);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat kind %0d byte %02h status %0d",
                                    out_kind, out_byte, out_status));
        end else begin
          want = expected_beats.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
          n_checked++;
          if (want.kind == KIND_VERDICT) n_verdicts++;
        end
      end
      if (flush && !flushed) begin
        flushed = 1'b1;
        if (expected_beats.size() != 0)
          report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
      end
    end
    fail_count       <= n_fails;
    pending          <= expected_beats.size();
    beats_checked    <= n_checked;
    verdicts_checked <= n_verdicts;
  end

endmodule

### test/tb_http_request_line_parser.sv
// tb_http_request_line_parser: drives request lines into the parser under three
// idle patterns and reports the verdict; depends on hdl/hrlp_pkg.sv,
// hdl/http_request_line_parser.sv and test/hrlp_checker.sv
`timescale 1ns / 1ps

module tb_http_request_line_parser;

  import hrlp_pkg::*;

  localparam int ITEMS       = 550;   // random byte beats over the three phases
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN       = 8;     // settle time after the last expected beat

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_char_byte   = 8'h00;
  logic       in_end_of_line = 1'b0;
  logic       out_stall      = 1'b0;
  logic       flush          = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_last;

  int fail_count;
  int pending;
  int beats_checked;
  int verdicts_checked;

  // idle percentages, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int         quiet_cycles = 0;
  int         lines_sent   = 0;
  int         beats_sent   = 0;
  logic [7:0] line_buf [$];

  http_request_line_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_byte   (in_char_byte),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  hrlp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_line   (in_end_of_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .flush            (flush),
    .fail_count       (fail_count),
    .pending          (pending),
    .beats_checked    (beats_checked),
    .verdicts_checked (verdicts_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, changed at the falling edge only
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: any handshake on either channel counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("http_request_line_parser test failed");
        $finish;
      end
    end
  end

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // one byte beat; valid stays high from one beat to the next unless an idle is drawn
  task send_beat(input logic [7:0] b, input logic eol);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_char_byte   <= b;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // whole line from line_buf, end of line flagged on its last byte
  task send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_beat(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
    beats_sent += line_buf.size();
  endtask

  // mostly well formed request lines with random content, some broken, some noise
  task build_random_line();
    int         pick;
    int         m;
    int         n;
    logic [7:0] c;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // plain noise, any byte value
      n = $urandom_range(1, 8);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end

    // method token: exact, cut short, one letter too many, or random letters
    pick = $urandom_range(0, 99);
    m    = (pick < 55) ? GET_IDX : $urandom_range(0, NUM_METHODS - 1);
    if (pick < 85) n = int'(METHOD_LEN[m]);
    else if (pick < 90) n = int'(METHOD_LEN[m]) - 1;
    else n = 0;
    for (int k = 0; k < n; k++) line_buf.push_back(METHOD_TEXT[m][k]);
    if (pick >= 80 && pick < 85) line_buf.push_back("S");
    if (pick >= 90) begin
      // up to ten letters, past the point where the method counter saturates
      n = $urandom_range(1, 10);
      repeat (n) line_buf.push_back(8'($urandom_range(8'h41, 8'h5a)));
    end
    line_buf.push_back(CH_SP);
    if ($urandom_range(0, 99) < 4) line_buf.push_back(CH_SP);

    // target: usually slash first, then a few bytes heavy in '?', '"' and '/'
    if ($urandom_range(0, 99) < 85) line_buf.push_back(CH_SLASH);
    n = $urandom_range(0, 6);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) c = CH_QMARK;
      else if (pick < 22) c = CH_QUOTE;
      else if (pick < 32) c = CH_SLASH;
      else if (pick < 45) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h61, 8'h7a));
      line_buf.push_back(c);
    end
    if ($urandom_range(0, 99) >= 4) line_buf.push_back(CH_SP);

    // version token
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      push_text("HTTP/1.1");
    end else if (pick < 75) begin
      push_text("HTTP/1.0");
    end else if (pick < 80) begin
      push_text("HTTP/1.");
    end else if (pick < 85) begin
      push_text("HTTP/1.11");
    end else if (pick < 90) begin
      // long enough to saturate the version counter
      push_text("HTTP/1.1");
      repeat ($urandom_range(8, 10)) line_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
    end else if (pick < 95) begin
      // stray cr inside the version
      push_text("HTTP/1");
      line_buf.push_back(CH_CR);
      push_text(".1");
    end else begin
      // doubled cr before the line end
      push_text("HTTP/1.1");
      line_buf.push_back(CH_CR);
    end

    // line end: proper crlf, half of one, none, or bytes after it
    pick = $urandom_range(0, 99);
    if (pick < 80 || pick >= 95) begin
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_LF);
    end else if (pick < 85) begin
      line_buf.push_back(CH_CR);
    end else if (pick < 90) begin
      line_buf.push_back(CH_LF);
    end
    if (pick >= 95) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
    end

    // now and then the line ends early, anywhere
    if ($urandom_range(0, 99) < 5) begin
      n = $urandom_range(1, line_buf.size());
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: quote and query split with a second '?' passed on as query
    line_buf.delete();
    push_text("GET /?a");
    line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_QMARK);
    push_text(" HTTP/1.1");
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
    send_line();
    // directed: all-ones byte that ends the line in the method token
    line_buf.delete();
    line_buf.push_back(8'hff);
    send_line();
    // directed: zero byte as a target byte that also ends the line
    line_buf.delete();
    line_buf.push_back(CH_SP);
    line_buf.push_back(8'h00);
    send_line();

    // random, three idle patterns
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 13;
          recv_stall_pct = 58;
        end
        1: begin
          send_idle_pct  = 58;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      goal = beats_sent + ITEMS / 3;
      while (beats_sent < goal) begin
        build_random_line();
        send_line();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain: every expected beat in, then a few quiet cycles
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    flush <= 1'b1;
    repeat (2) @(posedge clk);

    $display("sent %0d request lines, %0d byte beats, under three idle patterns",
             lines_sent, beats_sent);
    $display("checked %0d result beats, %0d of them verdicts", beats_checked,
             verdicts_checked);
    if (fail_count == 0) begin
      $display("http_request_line_parser test passed");
    end else begin
      $display("http_request_line_parser test failed");
    end
    $finish;
  end

endmodule
